[hdl/gdfw_pkg.sv]
package gdfw_pkg;

   // Graph bounds.
   localparam int NUM_VERTICES = 32;
   localparam int MAX_EDGES    = 128;

   // Field and storage widths.
   localparam int VTX_W   = 5;                          // vertex number
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 6;                          // vertex_count register
   localparam int EDGE_AW = $clog2(MAX_EDGES);          // edge store address
   localparam int LINK_W  = $clog2(MAX_EDGES + 1);      // edge index or empty marker
   localparam int DEPTH_W = $clog2(NUM_VERTICES + 1);   // walk stack depth
   localparam int ENTRY_W = VTX_W + LINK_W;

   localparam logic [LINK_W-1:0] NO_EDGE = LINK_W'(MAX_EDGES);

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ADD_DIR   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD_UNDIR = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WALK      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [VTX_W-1:0]  first_vertex;
      logic [VTX_W-1:0]  second_vertex;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]  vertex;
      logic              found;
      logic              last;
      logic [STAT_W-1:0] status;
   } rsp_type;

   // One edge store entry: target vertex and link to the next entry of the list.
   typedef struct packed {
      logic [VTX_W-1:0]  target;
      logic [LINK_W-1:0] link;
   } edge_entry_type;

endpackage

[hdl/gdfw_ram.sv]
module gdfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/graph_depth_first_walker_unit.sv]
// Adds, clears and range errors give a single result each. Walks and path queries read the
// edge store one entry at a time, each read back before the next is issued, and pop vertices
// as their lists run out; busy is high meanwhile.
// Walk results wait for the next discovery or the walk's end so the final one can carry last.
// Results are single-cycle strobes on rsp_valid; the receiver cannot stall.
// Reset (synchronous): marks cleared, lists empty, edge count 0, vertex_count 32.
module graph_depth_first_walker_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  gdfw_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   output gdfw_pkg::rsp_type               rsp_data,
   // vertex_count register
   input  logic                            csr_wr_en,
   input  logic [gdfw_pkg::CNT_W-1:0]      csr_wr_data
);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;  // checks, first edge filing, walk setup
   localparam logic [2:0] S_FILE2  = 3'd2;  // forward entry of an undirected add
   localparam logic [2:0] S_TOP    = 3'd3;  // inspect stack top, pop or read edge
   localparam logic [2:0] S_EDGE   = 3'd4;  // edge entry back from the store

   logic [2:0]                     state_ff, state_in;
   logic [gdfw_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [gdfw_pkg::VTX_W-1:0]     a_ff, a_in;
   logic [gdfw_pkg::VTX_W-1:0]     b_ff, b_in;
   logic [gdfw_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [gdfw_pkg::LINK_W-1:0]    used_ff, used_in;
   logic [gdfw_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   logic [gdfw_pkg::NUM_VERTICES-1:0] marks_ff, marks_in;
   logic [gdfw_pkg::LINK_W-1:0]    heads_ff [gdfw_pkg::NUM_VERTICES];
   logic [gdfw_pkg::LINK_W-1:0]    heads_in [gdfw_pkg::NUM_VERTICES];
   // walk stack: only the next-edge pointer of each frame is ever needed
   logic [gdfw_pkg::LINK_W-1:0]    stack_ff [gdfw_pkg::NUM_VERTICES];
   logic [gdfw_pkg::LINK_W-1:0]    stack_in [gdfw_pkg::NUM_VERTICES];
   gdfw_pkg::rsp_type              pend_ff, pend_in;   // held walk result
   gdfw_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // edge store port
   logic                           ram_wr_en;
   logic [gdfw_pkg::EDGE_AW-1:0]   ram_wr_addr;
   gdfw_pkg::edge_entry_type       ram_wr_entry;
   logic                           ram_rd_en;
   logic [gdfw_pkg::EDGE_AW-1:0]   ram_rd_addr;
   logic [gdfw_pkg::ENTRY_W-1:0]   ram_rd_data;
   gdfw_pkg::edge_entry_type       ram_rd_entry;

   logic [gdfw_pkg::CNT_W-1:0]     count_use;
   logic                           a_bad, b_bad;
   logic                           room_one, room_two;
   logic [gdfw_pkg::VTX_W-1:0]     head_addr;
   logic [gdfw_pkg::LINK_W-1:0]    head_rd;
   logic [gdfw_pkg::DEPTH_W-1:0]   depth_dec;
   logic [gdfw_pkg::VTX_W-1:0]     top_idx;
   logic [gdfw_pkg::LINK_W-1:0]    top_link;
   logic                           is_walk;

   gdfw_ram #(
      .WIDTH (gdfw_pkg::ENTRY_W),
      .DEPTH (gdfw_pkg::MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_entry = gdfw_pkg::edge_entry_type'(ram_rd_data);

   // Counts above the vertex store size act as the full size.
   assign count_use = (count_ff > gdfw_pkg::CNT_W'(gdfw_pkg::NUM_VERTICES)) ?
                      gdfw_pkg::CNT_W'(gdfw_pkg::NUM_VERTICES) : count_ff;
   assign a_bad     = gdfw_pkg::CNT_W'(a_ff) >= count_use;
   assign b_bad     = gdfw_pkg::CNT_W'(b_ff) >= count_use;
   assign room_one  = used_ff < gdfw_pkg::LINK_W'(gdfw_pkg::MAX_EDGES);
   assign room_two  = used_ff <= gdfw_pkg::LINK_W'(gdfw_pkg::MAX_EDGES - 2);

   assign depth_dec = depth_ff - 1'b1;
   assign top_idx   = depth_dec[gdfw_pkg::VTX_W-1:0];
   assign top_link  = stack_ff[top_idx];
   assign is_walk   = (mode_ff == gdfw_pkg::MODE_WALK);

   // Single list-head read port: source of a filing, or vertex being pushed.
   always_comb begin
      head_addr = a_ff;
      if (state_ff == S_DECODE && mode_ff == gdfw_pkg::MODE_ADD_UNDIR) begin
         head_addr = b_ff;
      end else if (state_ff == S_EDGE) begin
         head_addr = ram_rd_entry.target;
      end
   end
   assign head_rd = heads_ff[head_addr];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      depth_in     = depth_ff;
      marks_in     = marks_ff;
      heads_in     = heads_ff;
      stack_in     = stack_ff;
      pend_in      = pend_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = used_ff[gdfw_pkg::EDGE_AW-1:0];
      ram_wr_entry = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = top_link[gdfw_pkg::EDGE_AW-1:0];

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_data.mode;
               a_in     = req_data.first_vertex;
               b_in     = req_data.second_vertex;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            rsp_in.last = 1'b1;
            case (mode_ff)
               gdfw_pkg::MODE_ADD_DIR, gdfw_pkg::MODE_ADD_UNDIR: begin
                  if (a_bad || b_bad) begin
                     rsp_in.status = gdfw_pkg::STAT_RANGE;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else if ((mode_ff == gdfw_pkg::MODE_ADD_UNDIR) ? !room_two
                                                                      : !room_one) begin
                     rsp_in.status = gdfw_pkg::STAT_FULL;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     // front insert: entry links to the old head
                     ram_wr_en           = 1'b1;
                     ram_wr_entry.link   = head_rd;
                     heads_in[head_addr] = used_ff;
                     used_in             = used_ff + 1'b1;
                     if (mode_ff == gdfw_pkg::MODE_ADD_UNDIR) begin
                        ram_wr_entry.target = a_ff;   // reverse entry first
                        state_in            = S_FILE2;
                     end else begin
                        ram_wr_entry.target = b_ff;
                        rsp_valid_in        = 1'b1;
                        state_in            = S_IDLE;
                     end
                  end
               end
               gdfw_pkg::MODE_WALK, gdfw_pkg::MODE_QUERY: begin
                  if (a_bad || (!is_walk && b_bad)) begin
                     rsp_in.status = gdfw_pkg::STAT_RANGE;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else if (!is_walk && a_ff == b_ff) begin
                     rsp_in.found = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     marks_in[a_ff] = 1'b1;
                     pend_in        = '0;
                     pend_in.vertex = a_ff;
                     stack_in[0]    = head_rd;
                     depth_in       = gdfw_pkg::DEPTH_W'(1);
                     state_in       = S_TOP;
                  end
               end
               gdfw_pkg::MODE_CLEAR: begin
                  marks_in     = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end

         S_FILE2: begin
            ram_wr_en           = 1'b1;
            ram_wr_entry.target = b_ff;
            ram_wr_entry.link   = head_rd;
            heads_in[head_addr] = used_ff;
            used_in             = used_ff + 1'b1;
            rsp_in.last         = 1'b1;
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end

         S_TOP: begin
            if (top_link >= gdfw_pkg::NO_EDGE) begin
               // list exhausted: pop; an empty stack ends the walk or query
               depth_in = depth_dec;
               if (depth_dec == '0) begin
                  rsp_valid_in = 1'b1;
                  if (is_walk) begin
                     rsp_in = pend_ff;
                  end
                  rsp_in.last = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_EDGE;
            end
         end

         S_EDGE: begin
            stack_in[top_idx] = ram_rd_entry.link;
            state_in          = S_TOP;
            if (marks_ff[ram_rd_entry.target]) begin
               // already reached, move on to the next entry
            end else if (!is_walk && ram_rd_entry.target == b_ff) begin
               rsp_in.found = 1'b1;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               depth_in     = '0;
               state_in     = S_IDLE;
            end else begin
               marks_in[ram_rd_entry.target] = 1'b1;
               if (is_walk) begin
                  rsp_in         = pend_ff;   // previous one is known not last
                  rsp_valid_in   = 1'b1;
                  pend_in        = '0;
                  pend_in.vertex = ram_rd_entry.target;
               end
               stack_in[depth_ff[gdfw_pkg::VTX_W-1:0]] = head_rd;
               depth_in = depth_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= gdfw_pkg::CNT_W'(gdfw_pkg::NUM_VERTICES);
         used_ff      <= '0;
         depth_ff     <= '0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < gdfw_pkg::NUM_VERTICES; i++) begin
            heads_ff[i] <= gdfw_pkg::NO_EDGE;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         depth_ff     <= depth_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      stack_ff <= stack_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A final result appears only once the sequencer is back in idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> state_ff == S_IDLE)
      else $error("last result while sequencer busy");

   // Only walks produce results that are not final.
   a_mid_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> busy && mode_ff == gdfw_pkg::MODE_WALK)
      else $error("non-final result outside a walk");

   // The stack is never empty while it is being inspected.
   a_top_depth: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TOP |-> depth_ff != '0 && depth_ff <= gdfw_pkg::NUM_VERTICES)
      else $error("stack depth out of bounds");

   // The edge store never fills beyond its size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= gdfw_pkg::LINK_W'(gdfw_pkg::MAX_EDGES))
      else $error("edge count beyond store size");

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid_ff)
      else $error("request accepted without going busy");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
   import gdfw_pkg::*;

   // Mode codes that the block does not use: one result, status ok, no change
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

   // Directed stimulus rows: a request or a vertex_count write
   typedef enum logic {ROW_REQUEST, ROW_COUNT} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      req_type           req;
      logic              typed;     // expected result typed into the row
      rsp_type           want;
      logic [CNT_W-1:0]  count;
   } step_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_data    = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   graph_depth_first_walker_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Graph mirror: edge lists, marks and the vertex_count register
   // ---------------------------------------------------------------
   bit      visited [NUM_VERTICES];
   int      list_head [NUM_VERTICES];
   int      edge_to [MAX_EDGES];
   int      edge_next [MAX_EDGES];
   int      edge_fill;
   int      vertex_limit;          // raw register value, 0..63
   bit      one_slot_tried;        // undirected add seen with one free entry

   rsp_type walk_batch [$];        // results of the request being predicted
   rsp_type due_results [$];       // results still to come, oldest first
   rsp_type oldest_due;
   int      fail_count = 0;
   int      gap_pct    = 11;       // sender idle chance per request, percent

   step_row_type steps [$];

   function automatic int count_in_use();
      return (vertex_limit > NUM_VERTICES) ? NUM_VERTICES : vertex_limit;
   endfunction

   task automatic post_result(input int v, input logic hit, input logic [STAT_W-1:0] st);
      rsp_type x;
      x.vertex = VTX_W'(v);
      x.found  = hit;
      x.last   = 1'b0;
      x.status = st;
      walk_batch.push_back(x);
   endtask

   // new entry goes to the front of the source's list
   task automatic file_edge(input int src, input int dst);
      edge_to[edge_fill]   = dst;
      edge_next[edge_fill] = list_head[src];
      list_head[src]       = edge_fill;
      edge_fill++;
   endtask

   // Depth-first expansion from root. A walk reports every vertex it marks;
   // a query stops as soon as the target turns up among unmarked neighbours.
   task automatic expand_from(input int root, input int target, input bit query,
                              output bit hit);
      int stack_vtx [NUM_VERTICES];
      int stack_ptr [NUM_VERTICES];
      int depth;
      int top;
      int p;
      int nb;
      hit   = 1'b0;
      depth = 0;
      visited[root] = 1'b1;
      if (!query)
         post_result(root, 1'b0, STAT_OK);
      stack_vtx[0] = root;
      stack_ptr[0] = list_head[root];
      depth = 1;
      while (depth > 0) begin
         top = depth - 1;
         p   = stack_ptr[top];
         if (p >= MAX_EDGES) begin
            depth--;
            continue;
         end
         nb             = edge_to[p];
         stack_ptr[top] = edge_next[p];
         if (visited[nb])
            continue;
         if (query && nb == target) begin
            hit = 1'b1;
            break;
         end
         visited[nb] = 1'b1;
         if (!query && walk_batch.size() < NUM_VERTICES)
            post_result(nb, 1'b0, STAT_OK);
         if (depth < NUM_VERTICES) begin
            stack_vtx[depth] = nb;
            stack_ptr[depth] = list_head[nb];
            depth++;
         end
      end
   endtask

   // Fills walk_batch with the results one request causes, updating the mirror.
   task automatic compute_graph_results(input req_type r);
      int                cnt;
      int                a;
      int                b;
      bit                hit;
      logic [STAT_W-1:0] st;
      rsp_type           tail;
      walk_batch.delete();
      cnt = count_in_use();
      a   = int'(r.first_vertex);
      b   = int'(r.second_vertex);
      case (r.mode)
         MODE_ADD_DIR, MODE_ADD_UNDIR: begin
            st = STAT_OK;
            if (a >= cnt || b >= cnt)
               st = STAT_RANGE;
            else if (MAX_EDGES - edge_fill < ((r.mode == MODE_ADD_UNDIR) ? 2 : 1))
               st = STAT_FULL;
            else begin
               if (r.mode == MODE_ADD_UNDIR)
                  file_edge(b, a);
               file_edge(a, b);
            end
            post_result(0, 1'b0, st);
         end
         MODE_WALK: begin
            if (a >= cnt)
               post_result(0, 1'b0, STAT_RANGE);
            else
               expand_from(a, 0, 1'b0, hit);
         end
         MODE_QUERY: begin
            if (a >= cnt || b >= cnt)
               post_result(0, 1'b0, STAT_RANGE);
            else if (a == b)
               post_result(0, 1'b1, STAT_OK);
            else begin
               expand_from(a, b, 1'b1, hit);
               post_result(0, hit, STAT_OK);
            end
         end
         MODE_CLEAR: begin
            foreach (visited[i])
               visited[i] = 1'b0;
            post_result(0, 1'b0, STAT_OK);
         end
         default: post_result(0, 1'b0, STAT_OK);
      endcase
      tail      = walk_batch.pop_back();
      tail.last = 1'b1;
      walk_batch.push_back(tail);
   endtask

   // ---------------------------------------------------------------
   // Request driver: optional idle gap, then hold start until busy drops
   // ---------------------------------------------------------------
   task automatic issue_request(input req_type r, input logic typed, input rsp_type want);
      int gap;
      gap = 0;
      if ($urandom_range(99) < gap_pct)
         gap = $urandom_range(4, 1);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      compute_graph_results(r);
      if (typed) begin
         walk_batch.delete();
         walk_batch.push_back(want);
      end
      foreach (walk_batch[i])
         due_results.push_back(walk_batch[i]);
   endtask

   // sender holds off until every expected result is in and the block is idle
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [CNT_W-1:0] v);
      wait_for_drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      vertex_limit = int'(v);
   endtask

   // Random request: mostly in-range vertices, some out of range. Steers the
   // edge fill through exactly one free entry once, then tries an undirected add.
   function automatic req_type random_request();
      req_type r;
      int      cnt;
      int      pick;
      cnt  = count_in_use();
      pick = $urandom_range(99);
      if (pick < 30)
         r.mode = MODE_ADD_UNDIR;
      else if (pick < 45)
         r.mode = MODE_ADD_DIR;
      else if (pick < 62)
         r.mode = MODE_WALK;
      else if (pick < 80)
         r.mode = MODE_QUERY;
      else if (pick < 92)
         r.mode = MODE_CLEAR;
      else
         r.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      if (cnt > 0 && $urandom_range(99) < 90) begin
         r.first_vertex  = VTX_W'($urandom_range(cnt - 1));
         r.second_vertex = VTX_W'($urandom_range(cnt - 1));
      end else begin
         r.first_vertex  = VTX_W'($urandom_range(NUM_VERTICES - 1));
         r.second_vertex = VTX_W'($urandom_range(NUM_VERTICES - 1));
      end
      if (r.mode == MODE_ADD_UNDIR && edge_fill == MAX_EDGES - 2)
         r.mode = MODE_ADD_DIR;
      if (edge_fill == MAX_EDGES - 1 && !one_slot_tried && cnt > 0) begin
         one_slot_tried  = 1'b1;
         r.mode          = MODE_ADD_UNDIR;
         r.first_vertex  = VTX_W'($urandom_range(cnt - 1));
         r.second_vertex = VTX_W'($urandom_range(cnt - 1));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Directed table helpers
   // ---------------------------------------------------------------
   task automatic row_checked(input logic [MODE_W-1:0] m, input int a, input int b);
      step_row_type s;
      s       = '0;
      s.kind  = ROW_REQUEST;
      s.req   = '{mode: m, first_vertex: VTX_W'(a), second_vertex: VTX_W'(b)};
      steps.push_back(s);
   endtask

   task automatic row_typed(input logic [MODE_W-1:0] m, input int a, input int b,
                            input int v, input logic hit, input logic [STAT_W-1:0] st);
      step_row_type s;
      s       = '0;
      s.kind  = ROW_REQUEST;
      s.req   = '{mode: m, first_vertex: VTX_W'(a), second_vertex: VTX_W'(b)};
      s.typed = 1'b1;
      s.want  = '{vertex: VTX_W'(v), found: hit, last: 1'b1, status: st};
      steps.push_back(s);
   endtask

   task automatic row_count(input int v);
      step_row_type s;
      s       = '0;
      s.kind  = ROW_COUNT;
      s.count = CNT_W'(v);
      steps.push_back(s);
   endtask

   // ---------------------------------------------------------------
   // Result checker: every strobe must match the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            $display("%0t: result with none expected: vertex %0d found %0b last %0b status %0d",
                     $time, rsp_data.vertex, rsp_data.found, rsp_data.last, rsp_data.status);
            fail_count++;
         end else begin
            oldest_due = due_results.pop_front();
            if (rsp_data.vertex !== oldest_due.vertex || rsp_data.found !== oldest_due.found ||
                rsp_data.last !== oldest_due.last || rsp_data.status !== oldest_due.status)
            begin
               $display("%0t: mismatch: expected vertex %0d found %0b last %0b status %0d,",
                        $time, oldest_due.vertex, oldest_due.found, oldest_due.last,
                        oldest_due.status,
                        " got vertex %0d found %0b last %0b status %0d",
                        rsp_data.vertex, rsp_data.found, rsp_data.last, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int      phase_counts [7];
      int      drained_wait;
      req_type r;
      rsp_type none;

      none = '0;
      foreach (visited[i]) begin
         visited[i]   = 1'b0;
         list_head[i] = MAX_EDGES;      // empty list
      end
      edge_fill      = 0;
      vertex_limit   = NUM_VERTICES;
      one_slot_tried = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Empty graph after reset, then a small graph built by hand:
      // 0->31, 5<->31, 5->0, 5<->17.
      row_typed(MODE_WALK, 0, 0, 0, 1'b0, STAT_OK);
      row_typed(MODE_QUERY, 0, 0, 0, 1'b1, STAT_OK);
      row_typed(MODE_ADD_DIR, 0, 31, 0, 1'b0, STAT_OK);
      row_typed(MODE_ADD_UNDIR, 31, 5, 0, 1'b0, STAT_OK);
      row_typed(MODE_ADD_DIR, 5, 0, 0, 1'b0, STAT_OK);
      row_typed(MODE_ADD_UNDIR, 5, 17, 0, 1'b0, STAT_OK);
      row_typed(MODE_CLEAR, 0, 0, 0, 1'b0, STAT_OK);
      row_checked(MODE_WALK, 0, 0);
      row_checked(MODE_WALK, 0, 0);            // start already marked
      row_checked(MODE_QUERY, 31, 0);          // target already marked
      row_typed(MODE_CLEAR, 31, 31, 0, 1'b0, STAT_OK);
      row_checked(MODE_QUERY, 17, 0);          // stops early, marks stay
      row_typed(MODE_UNUSED_LO, 0, 0, 0, 1'b0, STAT_OK);
      row_typed(MODE_UNUSED_MID, 17, 5, 0, 1'b0, STAT_OK);
      row_typed(MODE_UNUSED_HI, 31, 31, 0, 1'b0, STAT_OK);
      // count lowered: out-of-range vertices rejected, stored edges still followed
      row_count(20);
      row_typed(MODE_ADD_DIR, 25, 0, 0, 1'b0, STAT_RANGE);
      row_typed(MODE_WALK, 31, 0, 0, 1'b0, STAT_RANGE);
      row_typed(MODE_QUERY, 0, 20, 0, 1'b0, STAT_RANGE);
      row_typed(MODE_CLEAR, 0, 0, 0, 1'b0, STAT_OK);
      row_checked(MODE_WALK, 5, 0);
      // zero count: nothing in range
      row_count(0);
      row_typed(MODE_QUERY, 0, 0, 0, 1'b0, STAT_RANGE);
      row_typed(MODE_WALK, 0, 0, 0, 1'b0, STAT_RANGE);
      // count above the vertex total acts as the total
      row_count(63);
      row_typed(MODE_ADD_DIR, 31, 31, 0, 1'b0, STAT_OK);
      row_checked(MODE_WALK, 31, 0);
      row_count(1);
      row_typed(MODE_ADD_UNDIR, 0, 0, 0, 1'b0, STAT_OK);
      row_checked(MODE_WALK, 0, 0);

      foreach (steps[i]) begin
         if (steps[i].kind == ROW_COUNT)
            write_vertex_count(steps[i].count);
         else
            issue_request(steps[i].req, steps[i].typed, steps[i].want);
      end

      // Random part in phases; the count is rewritten at each phase boundary
      // (block drained first). Sender idling: light, then heavy, then none.
      phase_counts = '{32, 12, 63, 1, 24, 2, 32};
      for (int ph = 0; ph < 7; ph++) begin
         write_vertex_count(CNT_W'(phase_counts[ph]));
         gap_pct = (ph < 3) ? 11 : (ph < 5) ? 45 : 0;
         for (int n = 0; n < 28; n++) begin
            if (ph == 3 && n == 16)
               wait_for_drain();
            r = random_request();
            issue_request(r, 1'b0, none);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      drained_wait = 0;
      while (due_results.size() != 0 && drained_wait < 5000) begin
         @(posedge clock);
         drained_wait++;
      end
      repeat (20) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, due_results.size());
         fail_count++;
      end

      if (fail_count == 0)
         $display("graph_depth_first_walker_unit regression: pass");
      else
         $display("graph_depth_first_walker_unit regression: fail");
      $finish;
   end

   // hang guard: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("graph_depth_first_walker_unit regression: fail");
      $finish;
   end

endmodule
